[rtl/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared constants and types for the segment box clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

    // default coordinate width (signed fixed point)
    localparam int COORD_WIDTH = 32;

    // axis codes
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;

    // endpoint slots in a packed point vector
    localparam int PT_AX = 0;
    localparam int PT_AY = 1;
    localparam int PT_BX = 2;
    localparam int PT_BY = 3;

    // box bound slots in a packed box vector
    localparam int BOX_LO_X = 0;
    localparam int BOX_LO_Y = 1;
    localparam int BOX_HI_X = 2;
    localparam int BOX_HI_Y = 3;

    // control travelling between clipping stages
    typedef struct packed {
        logic valid;
        logic ok;
    } t_ctl;

endpackage

`default_nettype wire

[rtl/sbc_seg_if.sv]
// ----------------------------------------------------------------------------
// sbc_seg_if
// Input channel: one segment and one box per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_seg_if #(
    parameter int W = sbc_pkg::COORD_WIDTH
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] p_x;
    logic signed [W-1:0] p_y;
    logic signed [W-1:0] q_x;
    logic signed [W-1:0] q_y;
    logic signed [W-1:0] box_lo_x;
    logic signed [W-1:0] box_lo_y;
    logic signed [W-1:0] box_hi_x;
    logic signed [W-1:0] box_hi_y;

    modport source (
        output valid, p_x, p_y, q_x, q_y, box_lo_x, box_lo_y, box_hi_x, box_hi_y,
        input  ready
    );
    modport sink (
        input  valid, p_x, p_y, q_x, q_y, box_lo_x, box_lo_y, box_hi_x, box_hi_y,
        output ready
    );
endinterface

`default_nettype wire

[rtl/sbc_clip_if.sv]
// ----------------------------------------------------------------------------
// sbc_clip_if
// Output channel: hit flag and clipped endpoints per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_clip_if #(
    parameter int W = sbc_pkg::COORD_WIDTH
) ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] clip_a_x;
    logic signed [W-1:0] clip_a_y;
    logic signed [W-1:0] clip_b_x;
    logic signed [W-1:0] clip_b_y;

    modport source (
        output valid, hit, clip_a_x, clip_a_y, clip_b_x, clip_b_y,
        input  ready
    );
    modport sink (
        input  valid, hit, clip_a_x, clip_a_y, clip_b_x, clip_b_y,
        output ready
    );
endinterface

`default_nettype wire

[rtl/sbc_edge.sv]
// ----------------------------------------------------------------------------
// sbc_edge
// Clips a segment against one box edge: classify, multiply, restoring
// divide one quotient bit per stage, then move the outside endpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_edge #(
    parameter int W    = sbc_pkg::COORD_WIDTH,
    parameter int D    = sbc_pkg::AXIS_X,
    parameter bit LOW  = 1'b1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_ce,
    input  wire sbc_pkg::t_ctl         i_ctl,
    input  wire logic [3:0][W-1:0]     i_pt,
    input  wire logic [3:0][W-1:0]     i_box,
    output sbc_pkg::t_ctl              o_ctl,
    output logic [3:0][W-1:0]          o_pt,
    output logic [3:0][W-1:0]          o_box
);

    localparam int O  = 1 - D;
    localparam int E  = LOW ? D : D + 2;
    localparam int NS = W + 2;

    typedef struct packed {
        sbc_pkg::t_ctl     ctl;
        logic              act;
        logic              mova;
        logic              neg;
        logic [W-1:0]      den;
        logic [W-1:0]      rem;
        logic [W-1:0]      low;
        logic [3:0][W-1:0] pt;
        logic [3:0][W-1:0] box;
    } t_st;

    t_st r_st [NS];
    t_st n_st [NS];
    t_st r_out;
    t_st n_out;

    // classify endpoints and form the operand magnitudes
    logic [W-1:0] w_ad, w_ao, w_bd, w_bo, w_e;
    logic         w_ba, w_bb, w_n1, w_n2, w_n3;

    always_comb begin
        w_ad = i_pt[D];
        w_ao = i_pt[O];
        w_bd = i_pt[2 + D];
        w_bo = i_pt[2 + O];
        w_e  = i_box[E];
        w_ba = LOW ? ($signed(w_ad) < $signed(w_e)) : ($signed(w_e) < $signed(w_ad));
        w_bb = LOW ? ($signed(w_bd) < $signed(w_e)) : ($signed(w_e) < $signed(w_bd));
        w_n1 = $signed(w_e) < $signed(w_ad);
        w_n2 = $signed(w_bo) < $signed(w_ao);
        w_n3 = $signed(w_bd) < $signed(w_ad);

        n_st[0].ctl.valid = i_ctl.valid;
        n_st[0].ctl.ok    = i_ctl.ok & ~(w_ba & w_bb);
        n_st[0].act       = i_ctl.ok & (w_ba ^ w_bb);
        n_st[0].mova      = w_ba;
        n_st[0].neg       = w_n1 ^ w_n2 ^ w_n3;
        n_st[0].rem       = w_n1 ? (w_ad - w_e)  : (w_e - w_ad);
        n_st[0].low       = w_n2 ? (w_ao - w_bo) : (w_bo - w_ao);
        n_st[0].den       = w_n3 ? (w_ad - w_bd) : (w_bd - w_ad);
        n_st[0].pt        = i_pt;
        n_st[0].box       = i_box;
    end

    // product of the two magnitudes, high half seeds the remainder
    logic [2*W-1:0] w_prod;

    always_comb begin
        w_prod  = {{W{1'b0}}, r_st[0].rem} * {{W{1'b0}}, r_st[0].low};
        n_st[1] = r_st[0];
        n_st[1].rem = w_prod[2*W-1:W];
        n_st[1].low = w_prod[W-1:0];
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < W; j++) begin : g_div
        logic [W:0] w_t;
        logic [W:0] w_d;
        logic       w_ge;

        always_comb begin
            w_t  = {r_st[j+1].rem, r_st[j+1].low[W-1]};
            w_d  = w_t - {1'b0, r_st[j+1].den};
            w_ge = w_t >= {1'b0, r_st[j+1].den};
            n_st[j+2]     = r_st[j+1];
            n_st[j+2].rem = w_ge ? w_d[W-1:0] : w_t[W-1:0];
            n_st[j+2].low = {r_st[j+1].low[W-2:0], w_ge};
        end
    end

    // move the outside endpoint onto the edge
    logic [W-1:0] w_v;

    always_comb begin
        n_out = r_st[NS-1];
        w_v   = r_st[NS-1].neg ? (r_st[NS-1].pt[O] - r_st[NS-1].low)
                               : (r_st[NS-1].pt[O] + r_st[NS-1].low);
        if (r_st[NS-1].act) begin
            if (r_st[NS-1].mova) begin
                n_out.pt[D] = r_st[NS-1].box[E];
                n_out.pt[O] = w_v;
            end else begin
                n_out.pt[2 + D] = r_st[NS-1].box[E];
                n_out.pt[2 + O] = w_v;
            end
        end
    end

    // stage registers, valid bits cleared by reset
    for (genvar k = 0; k < NS; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].ctl.valid <= 1'b0;
            end else if (i_ce) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.ctl.valid <= 1'b0;
        end else if (i_ce) begin
            r_out <= n_out;
        end
    end

    assign o_ctl = r_out.ctl;
    assign o_pt  = r_out.pt;
    assign o_box = r_out.box;

endmodule

`default_nettype wire

[rtl/segment_box_clipper_unit.sv]
// Throughput: one segment per cycle while the output is not stalled; each edge is
// a multiply followed by a divider with one quotient bit per stage, all advancing
// together. A stalled output holds the whole pipeline in place.
// Reset (synchronous, active low) clears every valid bit; no clearing pass.
// ----------------------------------------------------------------------------
// segment_box_clipper_unit
// Clips a 2D segment against a box: x-low, x-high, y-low, y-high edges.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_clipper_unit #(
    parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbc_seg_if.sink    i_seg,
    sbc_clip_if.source o_clip
);

    localparam int W = COORD_WIDTH;

    logic                  w_ce;
    sbc_pkg::t_ctl         w_ctl [5];
    logic [3:0][W-1:0]     w_pt  [5];
    logic [3:0][W-1:0]     w_box [5];

    // global advance: move on unless a finished result is waiting
    assign w_ce        = ~o_clip.valid | o_clip.ready;
    assign i_seg.ready = w_ce;

    // pack the input transfer
    always_comb begin
        w_ctl[0].valid = i_seg.valid;
        w_ctl[0].ok    = 1'b1;
        w_pt[0][sbc_pkg::PT_AX]      = i_seg.p_x;
        w_pt[0][sbc_pkg::PT_AY]      = i_seg.p_y;
        w_pt[0][sbc_pkg::PT_BX]      = i_seg.q_x;
        w_pt[0][sbc_pkg::PT_BY]      = i_seg.q_y;
        w_box[0][sbc_pkg::BOX_LO_X]  = i_seg.box_lo_x;
        w_box[0][sbc_pkg::BOX_LO_Y]  = i_seg.box_lo_y;
        w_box[0][sbc_pkg::BOX_HI_X]  = i_seg.box_hi_x;
        w_box[0][sbc_pkg::BOX_HI_Y]  = i_seg.box_hi_y;
    end

    // the edge clippers in fixed order: x-low, x-high, y-low, y-high
    for (genvar g = 0; g < 4; g++) begin : g_edge
        sbc_edge #(
            .W   (W),
            .D   ((g < 2) ? sbc_pkg::AXIS_X : sbc_pkg::AXIS_Y),
            .LOW ((g % 2) == 0)
        ) u_edge (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_ctl   (w_ctl[g]),
            .i_pt    (w_pt[g]),
            .i_box   (w_box[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_pt    (w_pt[g+1]),
            .o_box   (w_box[g+1])
        );
    end

    // result, endpoints zeroed on reject
    assign o_clip.valid    = w_ctl[4].valid;
    assign o_clip.hit      = w_ctl[4].ok;
    assign o_clip.clip_a_x = w_ctl[4].ok ? w_pt[4][sbc_pkg::PT_AX] : '0;
    assign o_clip.clip_a_y = w_ctl[4].ok ? w_pt[4][sbc_pkg::PT_AY] : '0;
    assign o_clip.clip_b_x = w_ctl[4].ok ? w_pt[4][sbc_pkg::PT_BX] : '0;
    assign o_clip.clip_b_y = w_ctl[4].ok ? w_pt[4][sbc_pkg::PT_BY] : '0;

`ifndef SYNTHESIS
    // no result comes out of the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_clip.valid)
        else $error("result valid after reset");

    // a waiting result keeps its endpoints
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clip.valid && !o_clip.ready |=> $stable(w_pt[4]) && $stable(w_ctl[4]))
        else $error("stalled result changed");

    // a clipped first endpoint lies within the box in x
    a_hit_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clip.valid && o_clip.hit |->
            ($signed(w_pt[4][sbc_pkg::PT_AX]) >= $signed(w_box[4][sbc_pkg::BOX_LO_X]))
            && ($signed(w_pt[4][sbc_pkg::PT_AX]) <= $signed(w_box[4][sbc_pkg::BOX_HI_X])))
        else $error("hit endpoint outside box");
`endif

endmodule

`default_nettype wire

[tb/segment_box_clipper_unit_tb.sv]
// ----------------------------------------------------------------------------
// segment_box_clipper_unit_tb
// Drives segments and boxes into the clipper with random gaps on both sides.
// Each result is compared with a local prediction of the x-low, x-high, y-low and y-high edge clips.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module segment_box_clipper_unit_tb;

    localparam int W         = sbc_pkg::COORD_WIDTH;
    localparam int STALL_MAX = 20000;
    localparam int DRAIN     = 4 * (W + 3) + 20;

    typedef logic signed [W-1:0] t_coord;

    typedef struct packed {
        t_coord px, py, qx, qy, lox, loy, hix, hiy;
    } t_seg;

    typedef struct packed {
        logic   hit;
        t_coord ax, ay, bx, by;
    } t_clip;

    logic i_clk;
    logic i_rst_n;

    sbc_seg_if  #(.W(W)) seg_bus ();
    sbc_clip_if #(.W(W)) clip_bus ();

    segment_box_clipper_unit #(.COORD_WIDTH(W)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus),
        .o_clip  (clip_bus)
    );

    t_clip  clips_due[$];
    int     n_errors;
    int     n_results;
    int     n_hits;
    int     n_segs;
    int     quiet_cycles;
    bit     idle_off;
    bit     timed_out;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // interpolate the other axis where the segment meets an edge
    function automatic t_coord edge_cross(t_coord ad, t_coord ao, t_coord bd,
                                          t_coord bo, t_coord e);
        logic signed [2*W+3:0] prod;
        logic signed [2*W+3:0] quot;
        logic signed [W+1:0]   den;
        den  = $signed({bd[W-1], bd}) - $signed({ad[W-1], ad});
        if (den == 0) return ao;
        prod = ($signed({e[W-1], e}) - $signed({ad[W-1], ad}))
             * ($signed({bo[W-1], bo}) - $signed({ao[W-1], ao}));
        quot = prod / den;
        return t_coord'(ao + quot);
    endfunction

    // one edge; lowside means values below e are beyond it
    function automatic bit clip_edge(ref t_coord a[2], ref t_coord b[2],
                                     input int d, input t_coord e, input bit lowside);
        bit     ba, bb;
        t_coord v;
        ba = lowside ? (a[d] < e) : (a[d] > e);
        bb = lowside ? (b[d] < e) : (b[d] > e);
        if (ba && bb) return 1'b0;
        if (ba || bb) begin
            v = edge_cross(a[d], a[1-d], b[d], b[1-d], e);
            if (ba) begin
                a[d] = e; a[1-d] = v;
            end else begin
                b[d] = e; b[1-d] = v;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_clip predict_clip(t_seg s);
        t_coord a[2];
        t_coord b[2];
        bit     ok;
        t_clip  r;
        a[sbc_pkg::AXIS_X] = s.px; a[sbc_pkg::AXIS_Y] = s.py;
        b[sbc_pkg::AXIS_X] = s.qx; b[sbc_pkg::AXIS_Y] = s.qy;
        ok = clip_edge(a, b, sbc_pkg::AXIS_X, s.lox, 1'b1);
        if (ok) ok = clip_edge(a, b, sbc_pkg::AXIS_X, s.hix, 1'b0);
        if (ok) ok = clip_edge(a, b, sbc_pkg::AXIS_Y, s.loy, 1'b1);
        if (ok) ok = clip_edge(a, b, sbc_pkg::AXIS_Y, s.hiy, 1'b0);
        r = '0;
        if (ok) begin
            r.hit = 1'b1;
            r.ax = a[sbc_pkg::AXIS_X]; r.ay = a[sbc_pkg::AXIS_Y];
            r.bx = b[sbc_pkg::AXIS_X]; r.by = b[sbc_pkg::AXIS_Y];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        n_errors++;
        $display("mismatch at result %0d: %s got %h want %h", n_results, what, got, want);
    endtask

    // sender: drops valid while idling, holds it until the transfer
    task automatic send_seg(t_seg s);
        while (!idle_off && $urandom_range(99) < 33) begin
            seg_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_bus.valid    <= 1'b1;
        seg_bus.p_x      <= s.px;  seg_bus.p_y      <= s.py;
        seg_bus.q_x      <= s.qx;  seg_bus.q_y      <= s.qy;
        seg_bus.box_lo_x <= s.lox; seg_bus.box_lo_y <= s.loy;
        seg_bus.box_hi_x <= s.hix; seg_bus.box_hi_y <= s.hiy;
        do @(posedge i_clk); while (!seg_bus.ready);
        clips_due.push_back(predict_clip(s));
        n_segs++;
    endtask

    // receiver ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) clip_bus.ready <= 1'b0;
        else clip_bus.ready <= idle_off || ($urandom_range(99) >= 33);
    end

    // check each result transfer
    always @(posedge i_clk) begin
        t_clip want;
        if (i_rst_n && clip_bus.valid && clip_bus.ready) begin
            if (clips_due.size() == 0) begin
                report_mismatch("unexpected result", W'(clip_bus.hit), '0);
            end else begin
                want = clips_due.pop_front();
                if (clip_bus.hit !== want.hit)
                    report_mismatch("hit", W'(clip_bus.hit), W'(want.hit));
                if (clip_bus.clip_a_x !== want.ax) report_mismatch("clip_a_x", clip_bus.clip_a_x, want.ax);
                if (clip_bus.clip_a_y !== want.ay) report_mismatch("clip_a_y", clip_bus.clip_a_y, want.ay);
                if (clip_bus.clip_b_x !== want.bx) report_mismatch("clip_b_x", clip_bus.clip_b_x, want.bx);
                if (clip_bus.clip_b_y !== want.by) report_mismatch("clip_b_y", clip_bus.clip_b_y, want.by);
                if (want.hit) n_hits++;
            end
            n_results++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((seg_bus.valid && seg_bus.ready) || (clip_bus.valid && clip_bus.ready))
            quiet_cycles <= 0;
        else if (i_rst_n) quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transfer for %0d cycles", STALL_MAX);
            $display("segment_box_clipper_unit_tb: errors");
            $finish;
        end
    end

    function automatic t_seg make_seg(int px, int py, int qx, int qy,
                                      int lx, int ly, int hx, int hy);
        t_seg s;
        s.px = px; s.py = py; s.qx = qx; s.qy = qy;
        s.lox = lx; s.loy = ly; s.hix = hx; s.hiy = hy;
        return s;
    endfunction

    function automatic t_coord rand_coord(t_coord c, int span);
        case ($urandom_range(3))
            0: return $urandom;
            default: return c + $signed($urandom_range(2 * span) - span);
        endcase
    endfunction

    task automatic test_directed();
        int mn, mx, u;
        mn = 32'h8000_0000; mx = 32'h7fff_ffff; u = 32'h0001_0000;
        // inside, unchanged
        send_seg(make_seg(u, u, 2*u, 3*u, 0, 0, 4*u, 4*u));
        // endpoints on edges are not beyond
        send_seg(make_seg(0, 0, 4*u, 4*u, 0, 0, 4*u, 4*u));
        // reject at each edge
        send_seg(make_seg(-2*u, 0, -u, u, 0, 0, 4*u, 4*u));
        send_seg(make_seg(5*u, 0, 6*u, u, 0, 0, 4*u, 4*u));
        send_seg(make_seg(u, -2*u, 2*u, -u, 0, 0, 4*u, 4*u));
        send_seg(make_seg(u, 5*u, 2*u, 6*u, 0, 0, 4*u, 4*u));
        // clip each edge once, ends a and b in turn
        send_seg(make_seg(-4*u, u, 2*u, 3*u, 0, 0, 4*u, 4*u));
        send_seg(make_seg(2*u, 3*u, 7*u, u, 0, 0, 4*u, 4*u));
        send_seg(make_seg(u, -3*u, 3*u, 2*u, 0, 0, 4*u, 4*u));
        send_seg(make_seg(3*u, 2*u, 1, 9*u, 0, 0, 4*u, 4*u));
        // negative truncation
        send_seg(make_seg(-3, 7, 4, -5, 0, -10, 10, 10));
        send_seg(make_seg(-7, 1, 3, 2, 0, -10, 10, 10));
        // crossing diagonally, both ends clipped
        send_seg(make_seg(-10*u, -7*u, 13*u, 11*u, -u, -u, 4*u, 4*u));
        // inverted boxes
        send_seg(make_seg(u, u, 2*u, 2*u, 4*u, 0, 0, 4*u));
        send_seg(make_seg(u, u, 2*u, 2*u, 0, 4*u, 4*u, 0));
        // full range extremes
        send_seg(make_seg(mn, mn, mx, mx, mn, mn, mx, mx));
        send_seg(make_seg(mn, mx, mx, mn, -1, -1, 1, 1));
        send_seg(make_seg(mx, mn, mn, mx, 0, 0, mx, mx));
        send_seg(make_seg(mn, 0, mx, 0, mx, mn, mx, mx));
        send_seg(make_seg(0, mn, 0, mx, mn, mn, mx, mn));
        send_seg(make_seg(mn, mn, mx, mx, 0, 0, 0, 0));
        // degenerate point
        send_seg(make_seg(u, u, u, u, 0, 0, 4*u, 4*u));
    endtask

    task automatic test_random(int count, bit wide);
        t_seg   s;
        t_coord cx, cy;
        int     span;
        repeat (count) begin
            if (wide || $urandom_range(9) == 0) begin
                s = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            end else begin
                // box near the segment so that clipping actually happens
                cx = $urandom; cy = $urandom;
                span = $urandom_range(1) ? $urandom_range(1000) : $urandom_range(32'h3fff_ffff);
                s.px = rand_coord(cx, span); s.py = rand_coord(cy, span);
                s.qx = rand_coord(cx, span); s.qy = rand_coord(cy, span);
                s.lox = cx - $urandom_range(span); s.hix = cx + $urandom_range(span);
                s.loy = cy - $urandom_range(span); s.hiy = cy + $urandom_range(span);
                if ($urandom_range(19) == 0) s.lox = s.hix + 1;
            end
            send_seg(s);
        end
    endtask

    task automatic test_back_to_back();
        idle_off = 1'b1;
        test_random(120, 1'b0);
        idle_off = 1'b0;
    endtask

    // stop sending and wait for every expected result
    task automatic wait_drained();
        seg_bus.valid <= 1'b0;
        while (clips_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        n_errors = 0; n_results = 0; n_hits = 0; n_segs = 0;
        quiet_cycles = 0; idle_off = 1'b0; timed_out = 1'b0;
        seg_bus.valid = 1'b0;
        {seg_bus.p_x, seg_bus.p_y, seg_bus.q_x, seg_bus.q_y} = '0;
        {seg_bus.box_lo_x, seg_bus.box_lo_y, seg_bus.box_hi_x, seg_bus.box_hi_y} = '0;
        clip_bus.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(200, 1'b0);
        // hold the sender until the pipeline has emptied
        wait_drained();
        test_back_to_back();
        test_random(100, 1'b1);
        test_random(110, 1'b0);

        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        $display("%0d segments sent, %0d results, %0d hits", n_segs, n_results, n_hits);
        if (n_errors == 0 && clips_due.size() == 0) begin
            $display("segment_box_clipper_unit_tb: clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_errors, clips_due.size());
            $display("segment_box_clipper_unit_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
